// File: design/dfbs_pkg.sv
package dfbs_pkg;

    localparam int PANELS_WIDE_DEF = 1;
    localparam int PANELS_HIGH_DEF = 1;
    localparam int PANEL_COLUMNS   = 32;
    localparam int PANEL_ROWS      = 16;

    // Wide enough for a buffer of up to 64 x 64 bytes.
    localparam int STORE_ADDR_W = 12;

    localparam logic [7:0] FILL_OFF = 8'hFF;
    localparam logic [7:0] FILL_ON  = 8'h00;
    localparam logic [7:0] MASK_MSB = 8'h80;

    typedef enum logic [2:0] {
        MODE_NORMAL  = 3'd0,
        MODE_INVERSE = 3'd1,
        MODE_TOGGLE  = 3'd2,
        MODE_CLEAR   = 3'd3,
        MODE_SCAN    = 3'd4
    } mode_t;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_FILL  = 2'd1,
        CMD_SCAN  = 2'd2
    } cmd_kind_t;

    typedef enum logic [1:0] {
        BOP_SET   = 2'd0,
        BOP_CLEAR = 2'd1,
        BOP_FLIP  = 2'd2
    } bit_op_t;

    typedef struct packed {
        logic [2:0] mode;
        logic [8:0] x;
        logic [7:0] y;
        logic       pixel;
    } req_t;

    typedef struct packed {
        logic [31:0] shift_word;
        logic [1:0]  row_select;
        logic        last;
    } rsp_t;

    typedef struct packed {
        cmd_kind_t               kind;
        bit_op_t                 bop;
        logic [STORE_ADDR_W-1:0] addr;
        logic [7:0]              mask;
        logic [7:0]              fill;
    } cmd_t;

    typedef struct packed {
        logic init_busy;
    } status_t;

endpackage

// File: design/dfbs_front.sv
module dfbs_front
    import dfbs_pkg::*;
#(
    parameter int PANELS_WIDE = PANELS_WIDE_DEF,
    parameter int PANELS_HIGH = PANELS_HIGH_DEF
) (
    input  logic    req_valid,
    output logic    req_stall,
    input  req_t    req,
    input  status_t status,
    input  logic    queue_full,
    output logic    push,
    output cmd_t    push_cmd
);

    localparam int ROW_BYTES = PANELS_WIDE * 4;
    localparam logic [9:0] DISP_W = 10'(PANELS_WIDE * PANEL_COLUMNS);
    localparam logic [8:0] DISP_H = 9'(PANELS_HIGH * PANEL_ROWS);

    logic in_range;
    logic keep;

    assign in_range = ({1'b0, req.x} < DISP_W) && ({1'b0, req.y} < DISP_H);

    always_comb
    begin
        keep          = 1'b0;
        push_cmd.kind = CMD_WRITE;
        push_cmd.bop  = BOP_SET;
        push_cmd.addr = STORE_ADDR_W'(req.y) * STORE_ADDR_W'(ROW_BYTES)
                        + STORE_ADDR_W'(req.x[8:3]);
        push_cmd.mask = MASK_MSB >> req.x[2:0];
        push_cmd.fill = req.pixel ? FILL_OFF : FILL_ON;
        unique case (req.mode)
            MODE_NORMAL:
            begin
                keep         = in_range;
                push_cmd.bop = req.pixel ? BOP_CLEAR : BOP_SET;
            end
            MODE_INVERSE:
            begin
                keep         = in_range;
                push_cmd.bop = req.pixel ? BOP_SET : BOP_CLEAR;
            end
            MODE_TOGGLE:
            begin
                keep         = in_range && req.pixel;
                push_cmd.bop = BOP_FLIP;
            end
            MODE_CLEAR:
            begin
                keep          = 1'b1;
                push_cmd.kind = CMD_FILL;
            end
            MODE_SCAN:
            begin
                keep          = 1'b1;
                push_cmd.kind = CMD_SCAN;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    assign req_stall = queue_full || status.init_busy;
    assign push      = req_valid && !req_stall && keep;

endmodule

// File: design/dfbs_queue.sv
module dfbs_queue
    import dfbs_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic head_valid,
    output cmd_t head
);

    cmd_t       entry_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head       = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// File: design/dfbs_back.sv
module dfbs_back
    import dfbs_pkg::*;
#(
    parameter int PANELS_WIDE = PANELS_WIDE_DEF,
    parameter int PANELS_HIGH = PANELS_HIGH_DEF
) (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    cmd_valid,
    input  cmd_t    cmd,
    output logic    cmd_pop,
    output status_t status,
    output logic    rsp_valid,
    input  logic    rsp_stall,
    output rsp_t    rsp
);

    localparam int ROW_BYTES   = PANELS_WIDE * 4;
    localparam int STORE_BYTES = ROW_BYTES * PANELS_HIGH * PANEL_ROWS;
    localparam int AW          = $clog2(STORE_BYTES);
    localparam int CW          = $clog2(ROW_BYTES);

    typedef enum logic [4:0] {
        ST_FILL     = 5'b00001,
        ST_IDLE     = 5'b00010,
        ST_RMW      = 5'b00100,
        ST_SCAN_RD  = 5'b01000,
        ST_SCAN_PUT = 5'b10000
    } state_t;

    logic [7:0] mem [STORE_BYTES];

    state_t      state_reg;
    state_t      state_next;
    logic        init_busy_reg;
    logic        init_busy_next;
    logic [AW-1:0] fill_cnt_reg;
    logic [AW-1:0] fill_cnt_next;
    logic [7:0]  fill_val_reg;
    logic [7:0]  fill_val_next;
    logic [1:0]  scan_row_reg;
    logic [1:0]  scan_row_next;
    logic [1:0]  quarter_reg;
    logic [1:0]  quarter_next;
    logic [CW-1:0] col_reg;
    logic [CW-1:0] col_next;
    logic        rsp_valid_reg;
    logic        rsp_valid_next;

    logic [AW-1:0] wr_addr_reg;
    logic [7:0]  wr_mask_reg;
    bit_op_t     bop_reg;
    logic [23:0] asm_reg;
    rsp_t        rsp_reg;
    logic [7:0]  rd_data_reg;

    logic        mem_we;
    logic [AW-1:0] mem_waddr;
    logic [7:0]  mem_wdata;
    logic        mem_re;
    logic [AW-1:0] mem_raddr;

    logic        rsp_free;
    logic        rsp_load;
    logic        col_last;
    logic [1:0]  rd_quarter;
    logic [CW-1:0] rd_col;
    logic [3:0]  rd_row;
    logic [AW-1:0] scan_addr;
    logic [7:0]  rmw_byte;

    assign rsp_free  = !rsp_valid_reg || !rsp_stall;
    assign col_last  = (col_reg == CW'(ROW_BYTES - 1));
    assign rd_row    = {~rd_quarter, scan_row_reg};
    assign scan_addr = AW'(rd_row) * AW'(ROW_BYTES) + AW'(rd_col);

    always_comb
    begin
        rd_quarter = quarter_reg;
        rd_col     = col_reg;
        if (state_reg == ST_SCAN_PUT && rsp_free && !col_last)
        begin
            rd_quarter = 2'd0;
            rd_col     = col_reg + CW'(1);
        end
    end

    always_comb
    begin
        unique case (bop_reg)
            BOP_SET:   rmw_byte = rd_data_reg | wr_mask_reg;
            BOP_CLEAR: rmw_byte = rd_data_reg & ~wr_mask_reg;
            BOP_FLIP:  rmw_byte = rd_data_reg ^ wr_mask_reg;
            default:   rmw_byte = rd_data_reg;
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        init_busy_next = init_busy_reg;
        fill_cnt_next  = fill_cnt_reg;
        fill_val_next  = fill_val_reg;
        scan_row_next  = scan_row_reg;
        quarter_next   = quarter_reg;
        col_next       = col_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_load       = 1'b0;
        cmd_pop        = 1'b0;
        mem_we         = 1'b0;
        mem_waddr      = fill_cnt_reg;
        mem_wdata      = fill_val_reg;
        mem_re         = 1'b0;
        mem_raddr      = scan_addr;
        unique case (state_reg)
            ST_FILL:
            begin
                mem_we = 1'b1;
                if (fill_cnt_reg == AW'(STORE_BYTES - 1))
                begin
                    fill_cnt_next  = '0;
                    init_busy_next = 1'b0;
                    state_next     = ST_IDLE;
                end
                else
                begin
                    fill_cnt_next = fill_cnt_reg + AW'(1);
                end
            end
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop = 1'b1;
                    unique case (cmd.kind)
                        CMD_WRITE:
                        begin
                            mem_re     = 1'b1;
                            mem_raddr  = cmd.addr[AW-1:0];
                            state_next = ST_RMW;
                        end
                        CMD_FILL:
                        begin
                            fill_val_next = cmd.fill;
                            state_next    = ST_FILL;
                        end
                        CMD_SCAN:
                        begin
                            state_next = ST_SCAN_RD;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_RMW:
            begin
                mem_we     = 1'b1;
                mem_waddr  = wr_addr_reg;
                mem_wdata  = rmw_byte;
                state_next = ST_IDLE;
            end
            ST_SCAN_RD:
            begin
                mem_re       = 1'b1;
                quarter_next = quarter_reg + 2'd1;
                if (quarter_reg == 2'd3)
                begin
                    state_next = ST_SCAN_PUT;
                end
            end
            ST_SCAN_PUT:
            begin
                if (rsp_free)
                begin
                    rsp_load       = 1'b1;
                    rsp_valid_next = 1'b1;
                    if (col_last)
                    begin
                        col_next      = '0;
                        scan_row_next = scan_row_reg + 2'd1;
                        state_next    = ST_IDLE;
                    end
                    else
                    begin
                        col_next     = col_reg + CW'(1);
                        mem_re       = 1'b1;
                        quarter_next = 2'd1;
                        state_next   = ST_SCAN_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_FILL;
            init_busy_reg <= 1'b1;
            fill_cnt_reg  <= '0;
            fill_val_reg  <= FILL_OFF;
            scan_row_reg  <= 2'd0;
            quarter_reg   <= 2'd0;
            col_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            init_busy_reg <= init_busy_next;
            fill_cnt_reg  <= fill_cnt_next;
            fill_val_reg  <= fill_val_next;
            scan_row_reg  <= scan_row_next;
            quarter_reg   <= quarter_next;
            col_reg       <= col_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE)
        begin
            wr_addr_reg <= cmd.addr[AW-1:0];
            wr_mask_reg <= cmd.mask;
            bop_reg     <= cmd.bop;
        end
        if (state_reg == ST_SCAN_RD)
        begin
            asm_reg <= {asm_reg[15:0], rd_data_reg};
        end
        if (rsp_load)
        begin
            rsp_reg.shift_word <= {asm_reg, rd_data_reg};
            rsp_reg.row_select <= scan_row_reg;
            rsp_reg.last       <= col_last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    assign status.init_busy = init_busy_reg;
    assign rsp_valid        = rsp_valid_reg;
    assign rsp              = rsp_reg;

endmodule

// File: design/dmd_frame_buffer_scanner.sv
// Channel   Valid       Stall       Payload   Moves
// request   req_valid   req_stall   req       one pixel, clear or scan item in
// response  rsp_valid   rsp_stall   rsp       one 32-bit shift word out
//
// A pixel write is a read-modify-write: the byte is read in ST_IDLE and written back in ST_RMW.
// A clear writes the fill byte to every address of the frame memory, one byte written per cycle.
// A scan sends PANELS_WIDE * 4 shift words, with four memory reads per shift word.
// After reset the memory is swept to all off while req_stall is held high.
// A two-entry command queue lets the request side run ahead while the response side stalls.
module dmd_frame_buffer_scanner
    import dfbs_pkg::*;
#(
    parameter int PANELS_WIDE = PANELS_WIDE_DEF,
    parameter int PANELS_HIGH = PANELS_HIGH_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    status_t status;
    logic    queue_full;
    logic    push;
    cmd_t    push_cmd;
    logic    pop;
    logic    head_valid;
    cmd_t    head;

    dfbs_front #(
        .PANELS_WIDE(PANELS_WIDE),
        .PANELS_HIGH(PANELS_HIGH)
    ) u_front (
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .status    (status),
        .queue_full(queue_full),
        .push      (push),
        .push_cmd  (push_cmd)
    );

    dfbs_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (push_cmd),
        .full      (queue_full),
        .pop       (pop),
        .head_valid(head_valid),
        .head      (head)
    );

    dfbs_back #(
        .PANELS_WIDE(PANELS_WIDE),
        .PANELS_HIGH(PANELS_HIGH)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd_valid(head_valid),
        .cmd      (head),
        .cmd_pop  (pop),
        .status   (status),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp      (rsp)
    );

endmodule
